[src/cla_pkg.sv]
// Shared types and constants for the console line assembler.
// No dependencies.
package cla_pkg;

  localparam int unsigned LINE_BUF_SIZE = 32;
  localparam int unsigned CntW          = $clog2(LINE_BUF_SIZE);
  localparam int unsigned LenW          = 5;

  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  typedef enum logic [2:0] {
    KIND_ECHO        = 3'd0,
    KIND_CHAR        = 3'd1,
    KIND_DONE        = 3'd2,
    KIND_REJECT      = 3'd3,
    KIND_DISCARD_END = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_LINE,
    S_CHAR,
    S_DONE,
    S_REJ,
    S_DEND
  } state_e;

endpackage

[src/console_line_assembler.sv]
// Console line assembler top level: echo, line editing and line output.
// Depends on cla_pkg and cla_ram.
//
// Every received byte is echoed, then edited into a line store of
// LINE_BUF_SIZE-1 characters held in one RAM. An accepted byte is registered
// and its echo is loaded into the output register once that register is free;
// a new byte is accepted only once the last result of the previous one is
// loaded into the output register. A CR or LF walks the store through the
// single RAM read port, reading each stored character in S_LINE and loading
// it in S_CHAR, then S_LINE finds the end of the line and S_DONE loads the
// done result. No clearing pass follows reset.
module console_line_assembler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cla_pkg::kind_e       out_kind_o,
  output logic [7:0]           out_byte_o,
  output logic [cla_pkg::LenW-1:0] line_length_o,
  output logic                 last_o
);

  import cla_pkg::*;

  localparam logic [CntW-1:0] FillMax = CntW'(LINE_BUF_SIZE - 1);

  state_e          state_q, state_d;
  logic [7:0]      byte_q, byte_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            discard_q, discard_d;

  logic            ovld_q, ovld_d;
  kind_e           okind_q, okind_d;
  logic [7:0]      obyte_q, obyte_d;
  logic [LenW-1:0] olen_q, olen_d;
  logic            olast_q, olast_d;

  logic            slot_free;
  logic            is_del, is_term, in_xfer;
  logic            ram_we, ram_re;
  logic [7:0]      ram_rdata;

  assign slot_free = !ovld_q || out_ready_i;
  assign is_del    = (byte_q == CHAR_DEL) || (byte_q == CHAR_BS);
  assign is_term   = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer   = in_valid_i && in_ready_o;

  cla_ram #(
    .Width (8),
    .Depth (LINE_BUF_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_ECHO;
      end
      S_ECHO: begin
        if (slot_free) begin
          if (discard_q) begin
            state_d = is_term ? S_DEND : S_IDLE;
          end else if (is_del) begin
            state_d = S_IDLE;
          end else if (is_term) begin
            state_d = S_LINE;
          end else if (fill_q != FillMax) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_REJ;
          end
        end
      end
      S_LINE: begin
        state_d = (idx_q == fill_q) ? S_DONE : S_CHAR;
      end
      S_CHAR: begin
        if (slot_free) state_d = S_LINE;
      end
      S_DONE, S_REJ, S_DEND: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    byte_d    = byte_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    discard_d = discard_q;
    ovld_d    = ovld_q && !out_ready_i;
    okind_d   = okind_q;
    obyte_d   = obyte_q;
    olen_d    = olen_q;
    olast_d   = olast_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) byte_d = rx_byte_i;
      end
      S_ECHO: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = KIND_ECHO;
          obyte_d = byte_q;
          olen_d  = '0;
          olast_d = 1'b1;
          idx_d   = '0;
          if (discard_q) begin
            if (is_term) begin
              olast_d   = 1'b0;
              discard_d = 1'b0;
              fill_d    = '0;
            end
          end else if (is_del) begin
            if (fill_q != '0) fill_d = fill_q - 1'b1;
          end else if (is_term) begin
            olast_d = 1'b0;
          end else if (fill_q != FillMax) begin
            ram_we = 1'b1;
            fill_d = fill_q + 1'b1;
          end else begin
            olast_d   = 1'b0;
            fill_d    = '0;
            discard_d = 1'b1;
          end
        end
      end
      S_LINE: begin
        if (idx_q != fill_q) ram_re = 1'b1;
      end
      S_CHAR: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = KIND_CHAR;
          obyte_d = ram_rdata;
          olen_d  = '0;
          olast_d = 1'b0;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = KIND_DONE;
          obyte_d = '0;
          olen_d  = LenW'(fill_q);
          olast_d = 1'b1;
          fill_d  = '0;
        end
      end
      S_REJ, S_DEND: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = (state_q == S_REJ) ? KIND_REJECT : KIND_DISCARD_END;
          obyte_d = '0;
          olen_d  = '0;
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      idx_q     <= '0;
      discard_q <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      discard_q <= discard_d;
      ovld_q    <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    okind_q <= okind_d;
    obyte_q <= obyte_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovld_q;
  assign out_kind_o    = okind_q;
  assign out_byte_o    = obyte_q;
  assign line_length_o = olen_q;
  assign last_o        = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count beyond store capacity");

  a_discard_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> fill_q == '0)
    else $error("line not empty in discard mode");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINE || state_q == S_CHAR) |-> idx_q <= fill_q)
    else $error("line read index past fill count");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

endmodule

[src/cla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read. No dependencies.
module cla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[test/cla_checker.sv]
`timescale 1ns / 100ps
// Checker for the console line assembler: watches both channels, predicts the
// echo and line output of every received byte and compares each result.
// Depends on cla_pkg.
module console_line_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [7:0]               rx_byte_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  cla_pkg::kind_e           out_kind_i,
  input  logic [7:0]               out_byte_i,
  input  logic [cla_pkg::LenW-1:0] line_length_i,
  input  logic                     last_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import cla_pkg::*;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic            last;
  } console_out_t;

  console_out_t console_out_q[$];
  logic [7:0]   line_text [LINE_BUF_SIZE-1];
  int           line_fill;
  bit           discarding;
  int           mismatches;

  task automatic push_out(input kind_e k, input logic [7:0] d, input logic [LenW-1:0] n,
                          input logic is_last);
    console_out_t r;
    r.kind = k;
    r.data = d;
    r.len  = n;
    r.last = is_last;
    console_out_q.push_back(r);
  endtask

  task automatic edit_console_line(input logic [7:0] c);
    bit is_term;
    is_term = (c == CHAR_CR) || (c == CHAR_LF);
    if (discarding) begin
      push_out(KIND_ECHO, c, '0, !is_term);
      if (is_term) begin
        discarding = 1'b0;
        line_fill  = 0;
        push_out(KIND_DISCARD_END, '0, '0, 1'b1);
      end
    end else if (c == CHAR_DEL || c == CHAR_BS) begin
      push_out(KIND_ECHO, c, '0, 1'b1);
      if (line_fill > 0) line_fill--;
    end else if (is_term) begin
      push_out(KIND_ECHO, c, '0, 1'b0);
      for (int i = 0; i < line_fill; i++) push_out(KIND_CHAR, line_text[i], '0, 1'b0);
      push_out(KIND_DONE, '0, LenW'(line_fill), 1'b1);
      line_fill = 0;
    end else if (line_fill < LINE_BUF_SIZE - 1) begin
      push_out(KIND_ECHO, c, '0, 1'b1);
      line_text[line_fill] = c;
      line_fill++;
    end else begin
      push_out(KIND_ECHO, c, '0, 1'b0);
      push_out(KIND_REJECT, '0, '0, 1'b1);
      line_fill  = 0;
      discarding = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_out_t seen;
    console_out_t want;
    if (!rst_ni) begin
      console_out_q.delete();
      line_fill    = 0;
      discarding   = 1'b0;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{out_kind_i, out_byte_i, line_length_i, last_i};
        if (console_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %h len %0d last %b",
                                    seen.kind, seen.data, seen.len, seen.last));
        end else begin
          want = console_out_q.pop_front();
          if (seen !== want) begin
            report_mismatch($sformatf("got kind %0d byte %h len %0d last %b, want %0d %h %0d %b",
                                      seen.kind, seen.data, seen.len, seen.last,
                                      want.kind, want.data, want.len, want.last));
          end
        end
      end
      if (in_valid_i && in_ready_i) edit_console_line(rx_byte_i);
      fail_count_o <= mismatches;
      pending_o    <= console_out_q.size();
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Top of the console line assembler testbench: clock, reset, byte and line
// stimulus, output-side stalls, watchdog and verdict.
// Depends on cla_pkg, console_line_assembler and console_line_checker.
module tb;
  import cla_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;

  typedef enum int {LINE_TYPICAL, LINE_FULL, LINE_OVERFLOW, LINE_NOISE} line_shape_e;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      rx_byte;
  logic            out_valid;
  logic            out_ready;
  kind_e           out_kind;
  logic [7:0]      out_byte;
  logic [LenW-1:0] line_length;
  logic            out_last;
  int              fail_count;
  int              pending;

  int tx_idle_pct;
  int rx_stall_pct;
  int bytes_sent;
  bit pressure_phase;
  bit pressure_held;
  int quiet_cycles;

  console_line_assembler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_kind_o    (out_kind),
    .out_byte_o    (out_byte),
    .line_length_o (line_length),
    .last_o        (out_last)
  );

  console_line_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_kind_i    (out_kind),
    .out_byte_i    (out_byte),
    .line_length_i (line_length),
    .last_i        (out_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_CR || c == CHAR_LF || c == CHAR_BS || c == CHAR_DEL);
    return c;
  endfunction

  function automatic logic [7:0] terminator();
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  function automatic logic [7:0] erase_char();
    return $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_line(input line_shape_e shape);
    int n;
    logic [7:0] c;
    case (shape)
      LINE_TYPICAL: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 9);
        for (int i = 0; i < n; i++) send_byte(($urandom_range(0, 99) < 15) ? erase_char()
                                                                             : plain_char());
        send_byte(terminator());
      end
      LINE_FULL: begin
        for (int i = 0; i < LINE_BUF_SIZE - 1; i++) send_byte(plain_char());
        if ($urandom_range(0, 1)) begin
          send_byte(erase_char());
          send_byte(plain_char());
        end
        send_byte(terminator());
      end
      LINE_OVERFLOW: begin
        for (int i = 0; i < LINE_BUF_SIZE; i++) send_byte(plain_char());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CHAR_CR || c == CHAR_LF);
          if ($urandom_range(0, 3) == 0) c = erase_char();
          send_byte(c);
        end
        send_byte(terminator());
      end
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_bytes);
    int target;
    int r;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_line(LINE_TYPICAL);
      else if (r < 65) send_line(LINE_FULL);
      else if (r < 77) send_line(LINE_OVERFLOW);
      else send_line(LINE_NOISE);
    end
  endtask

  initial begin
    logic [7:0] directed [$];
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    rx_byte      <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    bytes_sent   = 0;
    pressure_phase = 1'b0;
    directed = '{CHAR_CR, CHAR_LF, CHAR_BS, CHAR_DEL, 8'h00, 8'hFF, CHAR_BS, 8'h7E, 8'h80,
                 8'h01, CHAR_CR, 8'hFE, 8'h09, 8'h0B, 8'h0C, 8'h0E, CHAR_DEL, CHAR_DEL,
                 CHAR_LF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_byte(directed[i]);
    send_line(LINE_OVERFLOW);
    send_line(LINE_FULL);
    run_phase(0, 0, 50);
    run_phase(58, 0, 70);
    run_phase(0, 58, 70);
    run_phase(9, 9, 70);
    pressure_phase = 1'b1;
    run_phase(0, 0, 30);
    rx_stall_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    out_ready     <= 1'b0;
    pressure_held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pressure_phase && !pressure_held) begin
        pressure_held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(posedge clk_i);
          out_ready <= 1'b0;
        end
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule

[console_line_assembler.f]
src/cla_pkg.sv
src/cla_ram.sv
src/console_line_assembler.sv
test/cla_checker.sv
test/tb.sv
